/* hdl/dfe_pkg.sv */
// Shared types and constants of the display frame encoder.
// No dependencies; imported by every module of the block.
package dfe_pkg;

	// binary width of the conversion chain (trip/100 fits in 26 bits)
	localparam int Q_W = 26;
	localparam int SPD_W = 12;   // three BCD digits
	localparam int TRP_W = 20;   // five BCD digits

	// reciprocal of 100 scaled by 2^37, exact for every 32-bit dividend
	localparam logic [31:0] RECIP_100 = 32'h51EB851F;
	localparam int RECIP_SH = 37;

	localparam logic [3:0] LAST_IDX = 4'd11;
	localparam logic [3:0] GAP_LEN  = 4'd11;
	localparam logic [3:0] BLANK    = 4'hC;

	// frame bytes
	localparam logic [7:0] HDR0    = 8'hC1;
	localparam logic [7:0] HDR1    = 8'h29;
	localparam logic [7:0] CMD_DEF = 8'h27;
	localparam logic [7:0] CMD_STD = 8'h26;

	// frame positions
	localparam logic [3:0] B_HDR0 = 4'd0;
	localparam logic [3:0] B_HDR1 = 4'd1;
	localparam logic [3:0] B_CMD  = 4'd2;
	localparam logic [3:0] B_AST  = 4'd3;
	localparam logic [3:0] B_SEG1 = 4'd4;
	localparam logic [3:0] B_SEG2 = 4'd5;
	localparam logic [3:0] B_BAT  = 4'd6;
	localparam logic [3:0] B_TOPH = 4'd7;
	localparam logic [3:0] B_TOPL = 4'd8;
	localparam logic [3:0] B_BOTH = 4'd9;
	localparam logic [3:0] B_BOTM = 4'd10;
	localparam logic [3:0] B_BOTL = 4'd11;

	// register indexes
	localparam logic [2:0] R_SET_DEFAULT = 3'd0;
	localparam logic [2:0] R_CODE_SOLID  = 3'd1;
	localparam logic [2:0] R_CODE_OFF    = 3'd2;
	localparam logic [2:0] R_BATTERY     = 3'd3;
	localparam logic [2:0] R_MILES       = 3'd4;

	typedef struct packed {
		logic [2:0]  assist_step;
		logic        light_on;
		logic [15:0] speed_value;
		logic [31:0] trip_distance;
	} dfe_in_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic [3:0] byte_index;
		logic       last_byte;
	} dfe_out_t;

	typedef struct packed {
		logic       set_default;
		logic [1:0] code_solid;
		logic [1:0] code_off;
		logic [7:0] battery_level;
		logic       miles_units;
	} dfe_cfg_t;

	// one word travelling down the conversion chain
	typedef struct packed {
		logic             vld;
		logic [2:0]       assist;
		logic             light;
		logic [Q_W-1:0]   spd_bin;
		logic [Q_W-1:0]   trp_bin;
		logic [SPD_W-1:0] spd_bcd;
		logic [TRP_W-1:0] trp_bcd;
		logic             spd_ovf;
		logic             trp_ovf;
	} dfe_cell_t;

endpackage

/* hdl/dfe_cell.sv */
// One double-dabble step of the conversion chain: shifts one binary bit
// into the speed and trip BCD digits. Depends on dfe_pkg.
module dfe_cell import dfe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dfe_cell_t din,
	output dfe_cell_t dout
);

	dfe_cell_t out_s1;
	dfe_cell_t nxt;
	logic [SPD_W-1:0] spd_dab;
	logic [TRP_W-1:0] trp_dab;

	function automatic logic [3:0] add3(input logic [3:0] d);
		return (d >= 4'd5) ? d + 4'd3 : d;
	endfunction

	// correct each digit, then shift left with the next binary bit
	always_comb begin
		for (int i = 0; i < SPD_W / 4; i++) begin
			spd_dab[i*4 +: 4] = add3(din.spd_bcd[i*4 +: 4]);
		end
		for (int i = 0; i < TRP_W / 4; i++) begin
			trp_dab[i*4 +: 4] = add3(din.trp_bcd[i*4 +: 4]);
		end
		nxt         = din;
		nxt.spd_bin = {din.spd_bin[Q_W-2:0], 1'b0};
		nxt.trp_bin = {din.trp_bin[Q_W-2:0], 1'b0};
		nxt.spd_bcd = {spd_dab[SPD_W-2:0], din.spd_bin[Q_W-1]};
		nxt.trp_bcd = {trp_dab[TRP_W-2:0], din.trp_bin[Q_W-1]};
		// a carry out of the top digit means the value no longer fits
		nxt.spd_ovf = din.spd_ovf | spd_dab[SPD_W-1];
		nxt.trp_ovf = din.trp_ovf | trp_dab[TRP_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_s1 <= '0;
		end else begin
			out_s1 <= nxt;
		end
	end

	assign dout = out_s1;

endmodule

/* hdl/dfe_framer.sv */
// Frame builder and byte emitter: blanks leading zeros, holds one frame
// and sends its twelve bytes. Depends on dfe_pkg.
module dfe_framer import dfe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  dfe_cell_t din,
	input  dfe_cfg_t  cfg,
	output logic      strobe,
	output dfe_out_t  result
);

	logic             act_q;
	logic [3:0]       idx_q;
	logic [SPD_W-1:0] top_q;
	logic [TRP_W-1:0] bot_q;
	logic [2:0]       assist_q;
	logic             light_q;

	logic [SPD_W-1:0] top_d;
	logic [TRP_W-1:0] bot_d;
	logic [TRP_W/4:0] zero_above;
	logic [1:0]       light_code;
	logic [7:0]       assist_byte;
	logic [7:0]       byte_d;

	// leading blank: speed keeps two digits, trip keeps one
	always_comb begin
		top_d = din.spd_bcd;
		if (!din.spd_ovf && din.spd_bcd[11:8] == 4'd0) begin
			top_d[11:8] = BLANK;
		end
		bot_d = din.trp_bcd;
		zero_above[TRP_W/4] = 1'b1;
		for (int p = TRP_W / 4 - 1; p >= 0; p--) begin
			zero_above[p] = zero_above[p+1] && (din.trp_bcd[p*4 +: 4] == 4'd0);
		end
		for (int p = 1; p < TRP_W / 4; p++) begin
			if (!din.trp_ovf && zero_above[p]) begin
				bot_d[p*4 +: 4] = BLANK;
			end
		end
	end

	// byte sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			idx_q <= 4'd0;
		end else if (din.vld) begin
			act_q <= 1'b1;
			idx_q <= 4'd0;
		end else if (act_q) begin
			if (idx_q == LAST_IDX) begin
				act_q <= 1'b0;
			end else begin
				idx_q <= idx_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (din.vld) begin
			top_q    <= top_d;
			bot_q    <= bot_d;
			assist_q <= din.assist;
			light_q  <= din.light;
		end
	end

	// byte select
	always_comb begin
		light_code  = light_q ? cfg.code_solid : cfg.code_off;
		assist_byte = {6'd0, cfg.code_solid} << {assist_q, 1'b0};
		case (idx_q)
			B_HDR0: byte_d = HDR0;
			B_HDR1: byte_d = HDR1;
			B_CMD:  byte_d = cfg.set_default ? CMD_DEF : CMD_STD;
			B_AST:  byte_d = assist_byte;
			B_SEG1: byte_d = {light_code, cfg.code_solid, cfg.code_off, cfg.code_off};
			B_SEG2: byte_d = {cfg.code_solid, cfg.code_off, 2'b00, cfg.code_solid};
			B_BAT:  byte_d = cfg.battery_level;
			B_TOPH: byte_d = {{3{cfg.miles_units}}, 1'b0, top_q[11:8]};
			B_TOPL: byte_d = top_q[7:0];
			B_BOTH: byte_d = {cfg.code_solid, cfg.code_solid, bot_q[19:16]};
			B_BOTM: byte_d = bot_q[15:8];
			B_BOTL: byte_d = bot_q[7:0];
			default: byte_d = 8'd0;
		endcase
	end

	assign strobe            = act_q;
	assign result.frame_byte = byte_d;
	assign result.byte_index = idx_q;
	assign result.last_byte  = (idx_q == LAST_IDX);

endmodule

/* hdl/display_frame_encoder_unit.sv */
// Top level of the display frame encoder: config registers, divide stage,
// conversion chain of dfe_cell and the dfe_framer. Depends on dfe_pkg.
//
// Usage:
//   Items enter on item when start is high and busy is low. After an item is
//   taken busy stays high, so the next item must wait until busy falls; the
//   spacing is set by the twelve-byte emitter sharing one result port.
//   Trip is divided by 100 with one reciprocal multiply, then a row of 26
//   cells converts speed and trip to BCD, one bit per cell per cycle, with
//   several items in flight.
//   The first byte reaches result through head_s1, the cells and idx_q; the
//   twelve bytes follow on consecutive cycles, each marked by strobe for one
//   cycle, the last one with last_byte set. The receiver cannot stall; each
//   byte is gone after its cycle.
//   Config words are written on cfg_index/cfg_data when cfg_valid is high;
//   cfg_ready is always high. Indexes above 4 are ignored. Write only while
//   no frame is pending.
//   Reset clears the chain and emitter and loads the register defaults
//   (solid code 1, off code 0, battery 50).
module display_frame_encoder_unit import dfe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  dfe_in_t    item,
	output logic       strobe,
	output dfe_out_t   result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	dfe_cfg_t   cfg_q;
	logic [3:0] gap_q;
	logic       accept;
	logic [63:0] prod;
	dfe_cell_t  head_s1;
	dfe_cell_t  chain [0:Q_W];

	assign accept    = start && !busy;
	assign busy      = (gap_q != 4'd0);
	assign cfg_ready = 1'b1;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.set_default   <= 1'b0;
			cfg_q.code_solid    <= 2'd1;
			cfg_q.code_off      <= 2'd0;
			cfg_q.battery_level <= 8'd50;
			cfg_q.miles_units   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				R_SET_DEFAULT: cfg_q.set_default   <= cfg_data[0];
				R_CODE_SOLID:  cfg_q.code_solid    <= cfg_data[1:0];
				R_CODE_OFF:    cfg_q.code_off      <= cfg_data[1:0];
				R_BATTERY:     cfg_q.battery_level <= cfg_data;
				R_MILES:       cfg_q.miles_units   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item spacing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= 4'd0;
		end else if (accept) begin
			gap_q <= GAP_LEN;
		end else if (gap_q != 4'd0) begin
			gap_q <= gap_q - 4'd1;
		end
	end

	// trip / 100 by reciprocal, registered into the chain head
	assign prod = 64'(item.trip_distance) * 64'(RECIP_100);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_s1 <= '0;
		end else begin
			head_s1.vld     <= accept;
			head_s1.assist  <= item.assist_step;
			head_s1.light   <= item.light_on;
			head_s1.spd_bin <= Q_W'(item.speed_value);
			head_s1.trp_bin <= prod[RECIP_SH +: Q_W];
			head_s1.spd_bcd <= '0;
			head_s1.trp_bcd <= '0;
			head_s1.spd_ovf <= 1'b0;
			head_s1.trp_ovf <= 1'b0;
		end
	end

	assign chain[0] = head_s1;

	// conversion chain
	for (genvar g = 0; g < Q_W; g++) begin : g_cell
		dfe_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.din    (chain[g]),
			.dout   (chain[g+1])
		);
	end

	dfe_framer u_framer (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (chain[Q_W]),
		.cfg    (cfg_q),
		.strobe (strobe),
		.result (result)
	);

endmodule

/* hdl/dfe_checker.sv */
// Port-level checks of the display frame encoder, bound to the top level.
// Depends on dfe_pkg and display_frame_encoder_unit.
module dfe_checker import dfe_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input dfe_in_t    item,
	input logic       strobe,
	input dfe_out_t   result,
	input logic       cfg_valid,
	input logic       cfg_ready,
	input logic [2:0] cfg_index,
	input logic [7:0] cfg_data
);

	// a frame's bytes come without gaps
	a_contig: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.byte_index != LAST_IDX |=> strobe &&
		result.byte_index == $past(result.byte_index) + 4'd1)
		else $error("frame bytes not contiguous");

	// last marker only on the final byte
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (result.last_byte == (result.byte_index == LAST_IDX)))
		else $error("last marker misplaced");

	// every frame opens with the header byte
	a_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.byte_index == B_HDR0 |-> result.frame_byte == HDR0)
		else $error("bad header byte");

	// a taken word holds off the next one
	a_space: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after a word was taken");

endmodule

bind display_frame_encoder_unit dfe_checker u_dfe_checker (.*);
